@@ rtl/mtib_pkg.sv @@
// shared types, constants and the crc function of the mfm track image builder
package mtib_pkg;

    // field widths
    localparam int CMD_W   = 3;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 13;
    localparam int GAP3_W  = 7;
    localparam int CRC_W   = 16;
    localparam int STEP_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_BEGIN_TRACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SECTOR_HDR   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DATA_BYTE    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_END_SECTOR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_END_TRACK    = 3'd4;

    // raw track byte values
    localparam logic [BYTE_W-1:0] GAP_BYTE   = 8'h4e;
    localparam logic [BYTE_W-1:0] SYNC_BYTE  = 8'h00;
    localparam logic [BYTE_W-1:0] IAM_SYNC   = 8'hc2;
    localparam logic [BYTE_W-1:0] IAM_MARK   = 8'hfc;
    localparam logic [BYTE_W-1:0] AM_SYNC    = 8'ha1;
    localparam logic [BYTE_W-1:0] IDAM_MARK  = 8'hfe;
    localparam logic [BYTE_W-1:0] DAM_MARK   = 8'hfb;
    localparam logic [BYTE_W-1:0] DDAM_MARK  = 8'hf8;

    // run lengths
    localparam logic [POS_W-1:0] GAP0_LEN     = 13'd80;
    localparam logic [POS_W-1:0] SYNC_LEN     = 13'd12;
    localparam logic [POS_W-1:0] MARK_SYNC_LEN = 13'd3;
    localparam logic [POS_W-1:0] GAP1_LEN     = 13'd50;
    localparam logic [POS_W-1:0] GAP2_LEN     = 13'd22;
    localparam logic [POS_W-1:0] ONE_BYTE     = 13'd1;
    localparam logic [POS_W-1:0] POS_MAX      = 13'd8191;

    // gap3 choices by sector count
    localparam logic [GAP3_W-1:0] GAP3_FEW    = 7'h74;
    localparam logic [GAP3_W-1:0] GAP3_MID    = 7'h54;
    localparam logic [GAP3_W-1:0] GAP3_MANY   = 7'h33;
    localparam logic [GAP3_W-1:0] GAP3_DENSE  = 7'h10;
    localparam logic [BYTE_W-1:0] SECT_FEW    = 8'd5;
    localparam logic [BYTE_W-1:0] SECT_MID    = 8'd10;
    localparam logic [BYTE_W-1:0] SECT_MANY   = 8'd16;

    localparam logic [POS_W-1:0] TRACK_LENGTH_RESET = 13'h1800;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // job kinds handed from front to back
    typedef enum logic [2:0] {
        JOB_BEGIN,
        JOB_HEADER,
        JOB_DATA,
        JOB_END_SECTOR,
        JOB_END_TRACK
    } t_job_kind;

    typedef struct packed {
        t_job_kind                kind;
        logic [GAP3_W-1:0]        gap3;
        logic [3:0][BYTE_W-1:0]   id;
        logic [BYTE_W-1:0]        mark;
        logic [BYTE_W-1:0]        data;
    } t_job;

    typedef struct packed {
        logic  valid;
        t_job  job;
    } t_q_wr;

    typedef struct packed {
        logic  full;
        logic  empty;
    } t_q_status;

    // crc-16 ccitt update over one byte, msb first
    function automatic logic [CRC_W-1:0] crc_update(input logic [CRC_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ rtl/mtib_ifs.sv @@
// valid/ready channel interfaces for command input, run output and configuration

interface mtib_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] cmd;
    logic [7:0] sector_count;
    logic [7:0] id_cylinder;
    logic [7:0] id_head;
    logic [7:0] id_record;
    logic [7:0] id_size_code;
    logic       deleted_data;
    logic [7:0] payload_byte;

    modport source (output valid, cmd, sector_count, id_cylinder, id_head, id_record,
                    id_size_code, deleted_data, payload_byte, input ready);
    modport sink   (input valid, cmd, sector_count, id_cylinder, id_head, id_record,
                    id_size_code, deleted_data, payload_byte, output ready);
endinterface

interface mtib_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_value;
    logic [12:0] repeat_count;
    logic        last_of_run;
    logic        track_done;
    logic [12:0] bytes_used;
    logic        overflow;

    modport source (output valid, byte_value, repeat_count, last_of_run, track_done,
                    bytes_used, overflow, input ready);
    modport sink   (input valid, byte_value, repeat_count, last_of_run, track_done,
                    bytes_used, overflow, output ready);
endinterface

interface mtib_cfg_if;
    logic        valid;
    logic        ready;
    logic [12:0] track_length;

    modport source (output valid, track_length, input ready);
    modport sink   (input valid, track_length, output ready);
endinterface

@@ rtl/mtib_front.sv @@
// front end: accepts commands, drops unused codes and turns each into a job
module mtib_front import mtib_pkg::*; (
    mtib_in_if.sink    i_in,
    input  t_q_status  i_q_status,
    output t_q_wr      o_wr
);

    logic              w_known;
    t_job              w_job;

    // accept whenever the queue has room
    assign i_in.ready = !i_q_status.full;

    // decode command and precompute per-job constants
    always_comb begin
        w_known      = 1'b1;
        w_job.kind   = JOB_DATA;
        w_job.id     = {i_in.id_size_code, i_in.id_record, i_in.id_head, i_in.id_cylinder};
        w_job.data   = i_in.payload_byte;
        w_job.mark   = i_in.deleted_data ? DDAM_MARK : DAM_MARK;
        priority if (i_in.sector_count <= SECT_FEW) begin
            w_job.gap3 = GAP3_FEW;
        end else if (i_in.sector_count <= SECT_MID) begin
            w_job.gap3 = GAP3_MID;
        end else if (i_in.sector_count <= SECT_MANY) begin
            w_job.gap3 = GAP3_MANY;
        end else begin
            w_job.gap3 = GAP3_DENSE;
        end
        unique case (i_in.cmd)
            CMD_BEGIN_TRACK: w_job.kind = JOB_BEGIN;
            CMD_SECTOR_HDR:  w_job.kind = JOB_HEADER;
            CMD_DATA_BYTE:   w_job.kind = JOB_DATA;
            CMD_END_SECTOR:  w_job.kind = JOB_END_SECTOR;
            CMD_END_TRACK:   w_job.kind = JOB_END_TRACK;
            default:         w_known    = 1'b0;
        endcase
    end

    // push on every transfer of a known command
    assign o_wr.valid = i_in.valid && !i_q_status.full && w_known;
    assign o_wr.job   = w_job;

endmodule

@@ rtl/mtib_queue.sv @@
// small job queue between front and back ends
module mtib_queue import mtib_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_wr      i_wr,
    input  logic       i_pop,
    output t_job       o_head,
    output t_q_status  o_status
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push         = i_wr.valid && !o_status.full;
    assign w_pop          = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // pointer and count updates
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_wr.job;
        end
    end

endmodule

@@ rtl/mtib_back.sv @@
// back end: expands each job into runs, tracks position, overflow and crc
module mtib_back import mtib_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [POS_W-1:0]  i_track_length,
    input  t_job              i_head,
    input  t_q_status         i_q_status,
    output logic              o_pop,
    mtib_out_if.source        o_out
);

    logic [STEP_W-1:0] r_step,  n_step;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic              r_ovf,   n_ovf;
    logic [GAP3_W-1:0] r_gap3,  n_gap3;
    logic [CRC_W-1:0]  r_crc,   n_crc;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_byte_value;
    logic [POS_W-1:0]  r_repeat_count;
    logic              r_last_of_run;
    logic              r_track_done;
    logic [POS_W-1:0]  r_bytes_used;
    logic              r_overflow;

    logic              w_adv;
    logic [BYTE_W-1:0] w_value;
    logic [POS_W-1:0]  w_count;
    logic              w_last;
    logic              w_done;
    logic [POS_W-1:0]  w_base_pos;
    logic              w_base_ovf;
    logic [POS_W:0]    w_sum;
    logic [POS_W-1:0]  w_new_pos;
    logic              w_new_ovf;
    logic [POS_W-1:0]  w_pad;
    logic [1:0]        w_id_idx;
    logic [BYTE_W-1:0] w_crc_byte;
    logic [CRC_W-1:0]  w_crc_next;

    // one run per cycle while a job is queued and the output register is free or being taken
    assign w_adv = !i_q_status.empty && (!r_out_valid || o_out.ready);
    assign o_pop = w_adv && w_last;

    // shared crc unit: id bytes during a header, else the data byte
    assign w_id_idx   = 2'(r_step - 4'd3);
    assign w_crc_byte = (i_head.kind == JOB_HEADER) ? i_head.id[w_id_idx] : i_head.data;
    assign w_crc_next = crc_update(r_crc, w_crc_byte);

    // gap4 fill up to the track length
    assign w_pad = (r_pos < i_track_length) ? (i_track_length - r_pos) : '0;

    // run sequence per job kind
    always_comb begin
        w_value = GAP_BYTE;
        w_count = ONE_BYTE;
        w_last  = 1'b0;
        w_done  = 1'b0;
        unique case (i_head.kind)
            JOB_BEGIN: begin
                unique case (r_step)
                    4'd0:    begin w_value = GAP_BYTE;  w_count = GAP0_LEN;      end
                    4'd1:    begin w_value = SYNC_BYTE; w_count = SYNC_LEN;      end
                    4'd2:    begin w_value = IAM_SYNC;  w_count = MARK_SYNC_LEN; end
                    4'd3:    begin w_value = IAM_MARK;  w_count = ONE_BYTE;      end
                    default: begin w_value = GAP_BYTE;  w_count = GAP1_LEN; w_last = 1'b1; end
                endcase
            end
            JOB_HEADER: begin
                unique case (r_step)
                    4'd0:    begin w_value = SYNC_BYTE; w_count = SYNC_LEN;      end
                    4'd1:    begin w_value = AM_SYNC;   w_count = MARK_SYNC_LEN; end
                    4'd2:    begin w_value = IDAM_MARK; w_count = ONE_BYTE;      end
                    4'd3, 4'd4, 4'd5, 4'd6: begin
                        w_value = i_head.id[w_id_idx];
                        w_count = ONE_BYTE;
                    end
                    4'd7:    begin w_value = r_crc[15:8]; w_count = ONE_BYTE;    end
                    4'd8:    begin w_value = r_crc[7:0];  w_count = ONE_BYTE;    end
                    4'd9:    begin w_value = GAP_BYTE;  w_count = GAP2_LEN;      end
                    4'd10:   begin w_value = SYNC_BYTE; w_count = SYNC_LEN;      end
                    4'd11:   begin w_value = AM_SYNC;   w_count = MARK_SYNC_LEN; end
                    default: begin w_value = i_head.mark; w_count = ONE_BYTE; w_last = 1'b1; end
                endcase
            end
            JOB_DATA: begin
                w_value = i_head.data;
                w_count = ONE_BYTE;
                w_last  = 1'b1;
            end
            JOB_END_SECTOR: begin
                unique case (r_step)
                    4'd0:    begin w_value = r_crc[15:8]; w_count = ONE_BYTE; end
                    4'd1:    begin w_value = r_crc[7:0];  w_count = ONE_BYTE; end
                    default: begin
                        w_value = GAP_BYTE;
                        w_count = {{(POS_W-GAP3_W){1'b0}}, r_gap3};
                        w_last  = 1'b1;
                    end
                endcase
            end
            JOB_END_TRACK: begin
                w_value = GAP_BYTE;
                w_count = w_pad;
                w_last  = 1'b1;
                w_done  = 1'b1;
            end
            default: begin
                w_last = 1'b1;
            end
        endcase
    end

    // position and overflow, begin track starts from a clean track
    always_comb begin
        if (i_head.kind == JOB_BEGIN && r_step == '0) begin
            w_base_pos = '0;
            w_base_ovf = 1'b0;
        end else begin
            w_base_pos = r_pos;
            w_base_ovf = r_ovf;
        end
        w_sum     = {1'b0, w_base_pos} + {1'b0, w_count};
        w_new_pos = w_sum[POS_W] ? POS_MAX : w_sum[POS_W-1:0];
        w_new_ovf = w_base_ovf || (w_new_pos > i_track_length);
    end

    // next state of the sequencer and track state
    always_comb begin
        n_step = r_step;
        n_pos  = r_pos;
        n_ovf  = r_ovf;
        n_gap3 = r_gap3;
        n_crc  = r_crc;
        if (w_adv) begin
            n_step = w_last ? '0 : r_step + 1'b1;
            n_pos  = w_new_pos;
            n_ovf  = w_new_ovf;
            unique case (i_head.kind)
                JOB_BEGIN: begin
                    n_gap3 = i_head.gap3;
                    n_crc  = '0;
                end
                JOB_HEADER: begin
                    if (r_step == 4'd2 || w_last) begin
                        n_crc = '0;
                    end else if (r_step >= 4'd3 && r_step <= 4'd6) begin
                        n_crc = w_crc_next;
                    end
                end
                JOB_DATA: begin
                    n_crc = w_crc_next;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_gap3      <= '0;
            r_crc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            r_pos  <= n_pos;
            r_ovf  <= n_ovf;
            r_gap3 <= n_gap3;
            r_crc  <= n_crc;
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_byte_value   <= w_value;
            r_repeat_count <= w_count;
            r_last_of_run  <= w_last;
            r_track_done   <= w_done;
            r_bytes_used   <= w_new_pos;
            r_overflow     <= w_new_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.byte_value   = r_byte_value;
    assign o_out.repeat_count = r_repeat_count;
    assign o_out.last_of_run  = r_last_of_run;
    assign o_out.track_done   = r_track_done;
    assign o_out.bytes_used   = r_bytes_used;
    assign o_out.overflow     = r_overflow;

endmodule

@@ rtl/mfm_track_image_builder_top.sv @@
// top level of the mfm track image builder
// Builds a raw double-density track as runs of (byte value, repeat count) from
// begin track, sector header, data byte, end sector and end track commands. The
// front end takes one command per cycle while its four-entry job queue has room; the
// back end sequencer emits one run per cycle into a registered output while a job
// waits and that output is free or taken. Data byte and end track make one run, end
// sector three, begin track five, sector header thirteen. Codes five to seven are
// dropped with no result. Write track_length only while no runs are pending.
module mfm_track_image_builder_top import mtib_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mtib_in_if.sink     i_in,
    mtib_out_if.source  o_out,
    mtib_cfg_if.sink    i_cfg
);

    logic [POS_W-1:0] r_track_length;
    t_q_wr            w_wr;
    t_q_status        w_q_status;
    t_job             w_head;
    logic             w_pop;

    // configuration register, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_length <= TRACK_LENGTH_RESET;
        end else if (i_cfg.valid) begin
            r_track_length <= i_cfg.track_length;
        end
    end

    mtib_front u_front (
        .i_in       (i_in),
        .i_q_status (w_q_status),
        .o_wr       (w_wr)
    );

    mtib_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    mtib_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_track_length (r_track_length),
        .i_head         (w_head),
        .i_q_status     (w_q_status),
        .o_pop          (w_pop),
        .o_out          (o_out)
    );

endmodule

@@ bench/tb.sv @@
// self-checking bench for the mfm track image builder: track command driver, run monitor, scoreboard
`timescale 1ns / 100ps

module tb;
    import mtib_pkg::*;

    // unused command codes, dropped by the block
    localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

    localparam int IDLE_PCT    = 8;
    localparam int DRAIN_TICKS = 40;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 100;

    typedef struct packed {
        logic [CMD_W-1:0]       cmd;
        logic [BYTE_W-1:0]      sector_count;
        logic [3:0][BYTE_W-1:0] id;
        logic                   deleted;
        logic [BYTE_W-1:0]      payload;
    } t_track_cmd;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic [POS_W-1:0]  count;
        logic              last_run;
        logic              trk_done;
        logic [POS_W-1:0]  used;
        logic              ovf;
    } t_track_run;

    logic i_clk;
    logic i_rst_n;

    mtib_in_if  in_ch ();
    mtib_out_if out_ch ();
    mtib_cfg_if cfg_ch ();

    mfm_track_image_builder_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    t_track_cmd cmd_pending[$];
    t_track_run runs_due[$];
    t_track_cmd cmd_on_bus;

    // predicted block state
    logic [POS_W-1:0]  trk_len   = TRACK_LENGTH_RESET;
    logic [CRC_W-1:0]  data_crc  = '0;
    logic [POS_W-1:0]  pos       = '0;
    logic [GAP3_W-1:0] gap3_len  = '0;
    logic              ovf_seen  = 1'b0;

    bit calm = 1'b0;
    int fail_cnt    = 0;
    int queued_live = 0;
    int cmds_taken  = 0;
    int runs_seen   = 0;
    int tracks_seen = 0;
    int ovf_runs    = 0;
    int cycle_cnt   = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // ccitt crc over one byte, msb first
    function automatic logic [CRC_W-1:0] crc16_step(logic [CRC_W-1:0] c, logic [BYTE_W-1:0] b);
        logic fb;
        for (int k = BYTE_W - 1; k >= 0; k--) begin
            fb = c[CRC_W-1] ^ b[k];
            c  = {c[CRC_W-2:0], 1'b0};
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // one run of the predicted raw stream, position saturates
    task automatic add_run(logic [BYTE_W-1:0] v, logic [POS_W-1:0] n, logic lst, logic dn);
        logic [POS_W:0] sum;
        t_track_run r;
        sum = {1'b0, pos} + {1'b0, n};
        pos = (sum > {1'b0, POS_MAX}) ? POS_MAX : sum[POS_W-1:0];
        if (pos > trk_len) ovf_seen = 1'b1;
        r.value    = v;
        r.count    = n;
        r.last_run = lst;
        r.trk_done = dn;
        r.used     = pos;
        r.ovf      = ovf_seen;
        runs_due.push_back(r);
    endtask

    // expected runs of one accepted track command
    task automatic predict_track_runs(t_track_cmd c);
        logic [CRC_W-1:0] id_crc;
        logic [POS_W-1:0] pad;
        case (c.cmd)
            CMD_BEGIN_TRACK: begin
                pos      = '0;
                data_crc = '0;
                ovf_seen = 1'b0;
                if (c.sector_count <= SECT_FEW)       gap3_len = GAP3_FEW;
                else if (c.sector_count <= SECT_MID)  gap3_len = GAP3_MID;
                else if (c.sector_count <= SECT_MANY) gap3_len = GAP3_MANY;
                else                                  gap3_len = GAP3_DENSE;
                add_run(GAP_BYTE, GAP0_LEN, 1'b0, 1'b0);
                add_run(SYNC_BYTE, SYNC_LEN, 1'b0, 1'b0);
                add_run(IAM_SYNC, MARK_SYNC_LEN, 1'b0, 1'b0);
                add_run(IAM_MARK, ONE_BYTE, 1'b0, 1'b0);
                add_run(GAP_BYTE, GAP1_LEN, 1'b1, 1'b0);
            end
            CMD_SECTOR_HDR: begin
                add_run(SYNC_BYTE, SYNC_LEN, 1'b0, 1'b0);
                add_run(AM_SYNC, MARK_SYNC_LEN, 1'b0, 1'b0);
                add_run(IDAM_MARK, ONE_BYTE, 1'b0, 1'b0);
                id_crc = '0;
                for (int i = 0; i < 4; i++) begin
                    add_run(c.id[i], ONE_BYTE, 1'b0, 1'b0);
                    id_crc = crc16_step(id_crc, c.id[i]);
                end
                add_run(id_crc[15:8], ONE_BYTE, 1'b0, 1'b0);
                add_run(id_crc[7:0], ONE_BYTE, 1'b0, 1'b0);
                add_run(GAP_BYTE, GAP2_LEN, 1'b0, 1'b0);
                add_run(SYNC_BYTE, SYNC_LEN, 1'b0, 1'b0);
                add_run(AM_SYNC, MARK_SYNC_LEN, 1'b0, 1'b0);
                add_run(c.deleted ? DDAM_MARK : DAM_MARK, ONE_BYTE, 1'b1, 1'b0);
                data_crc = '0;
            end
            CMD_DATA_BYTE: begin
                add_run(c.payload, ONE_BYTE, 1'b1, 1'b0);
                data_crc = crc16_step(data_crc, c.payload);
            end
            CMD_END_SECTOR: begin
                add_run(data_crc[15:8], ONE_BYTE, 1'b0, 1'b0);
                add_run(data_crc[7:0], ONE_BYTE, 1'b0, 1'b0);
                add_run(GAP_BYTE, {{(POS_W-GAP3_W){1'b0}}, gap3_len}, 1'b1, 1'b0);
            end
            CMD_END_TRACK: begin
                pad = (pos < trk_len) ? trk_len - pos : '0;
                add_run(GAP_BYTE, pad, 1'b1, 1'b1);
            end
            default: ;
        endcase
    endtask

    // command with random content in every field
    function automatic t_track_cmd random_cmd(logic [CMD_W-1:0] op);
        t_track_cmd c;
        c.cmd          = op;
        c.sector_count = BYTE_W'($urandom);
        for (int i = 0; i < 4; i++) c.id[i] = BYTE_W'($urandom);
        c.deleted      = 1'($urandom);
        c.payload      = BYTE_W'($urandom);
        return c;
    endfunction

    task automatic push_cmd(t_track_cmd c);
        cmd_pending.push_back(c);
        if (c.cmd <= CMD_END_TRACK) queued_live++;
    endtask

    // mostly well-formed tracks with random content, some noise and broken tracks
    task automatic queue_random_tracks(int want);
        t_track_cmd c;
        int stop_at;
        int n_sec;
        int n_data;
        stop_at = queued_live + want;
        while (queued_live < stop_at) begin
            if ($urandom_range(9) == 0) begin
                push_cmd(random_cmd(CMD_W'($urandom_range(7))));
            end else begin
                if ($urandom_range(7) != 0) begin
                    c = random_cmd(CMD_BEGIN_TRACK);
                    if ($urandom_range(1)) c.sector_count = BYTE_W'($urandom_range(20));
                    push_cmd(c);
                end
                n_sec = $urandom_range(4);
                for (int s = 0; s < n_sec; s++) begin
                    if ($urandom_range(9) != 0) push_cmd(random_cmd(CMD_SECTOR_HDR));
                    n_data = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(8);
                    for (int d = 0; d < n_data; d++) push_cmd(random_cmd(CMD_DATA_BYTE));
                    push_cmd(random_cmd(CMD_END_SECTOR));
                end
                if ($urandom_range(5) != 0) push_cmd(random_cmd(CMD_END_TRACK));
            end
        end
    endtask

    // hold off until nothing is in flight, then let the pipeline settle
    task automatic wait_idle();
        while (cmd_pending.size() != 0 || in_ch.valid || runs_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_TICKS) @(posedge i_clk);
    endtask

    task automatic write_track_length(logic [POS_W-1:0] v);
        @(posedge i_clk);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.track_length <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        trk_len = v;
    endtask

    task automatic check_field(string name, int exp_v, int got_v);
        if (exp_v != got_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, got_v);
            fail_cnt++;
        end
    endtask

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_track_runs(cmd_on_bus);
                cmds_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (cmd_pending.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
                    cmd_on_bus = cmd_pending.pop_front();
                    in_ch.cmd          <= cmd_on_bus.cmd;
                    in_ch.sector_count <= cmd_on_bus.sector_count;
                    in_ch.id_cylinder  <= cmd_on_bus.id[0];
                    in_ch.id_head      <= cmd_on_bus.id[1];
                    in_ch.id_record    <= cmd_on_bus.id[2];
                    in_ch.id_size_code <= cmd_on_bus.id[3];
                    in_ch.deleted_data <= cmd_on_bus.deleted;
                    in_ch.payload_byte <= cmd_on_bus.payload;
                    in_ch.valid        <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // run monitor and scoreboard
    always @(posedge i_clk) begin
        t_track_run exp_r;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                runs_seen++;
                if (out_ch.track_done) tracks_seen++;
                if (out_ch.overflow) ovf_runs++;
                if (runs_due.size() == 0) begin
                    $error("unexpected run transfer: value %0h count %0d",
                           out_ch.byte_value, out_ch.repeat_count);
                    fail_cnt++;
                end else begin
                    exp_r = runs_due.pop_front();
                    check_field("byte_value", exp_r.value, out_ch.byte_value);
                    check_field("repeat_count", exp_r.count, out_ch.repeat_count);
                    check_field("last_of_run", exp_r.last_run, out_ch.last_of_run);
                    check_field("track_done", exp_r.trk_done, out_ch.track_done);
                    check_field("bytes_used", exp_r.used, out_ch.bytes_used);
                    check_field("overflow", exp_r.ovf, out_ch.overflow);
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d runs still due", cycle_cnt, runs_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // reset, directed track, then random tracks over several track lengths
    initial begin
        t_track_cmd c;
        logic [BYTE_W-1:0] gap3_edges [6];
        gap3_edges = '{8'd6, 8'd10, 8'd11, 8'd16, 8'd17, 8'd255};

        in_ch.valid         = 1'b0;
        in_ch.cmd           = '0;
        in_ch.sector_count  = '0;
        in_ch.id_cylinder   = '0;
        in_ch.id_head       = '0;
        in_ch.id_record     = '0;
        in_ch.id_size_code  = '0;
        in_ch.deleted_data  = 1'b0;
        in_ch.payload_byte  = '0;
        out_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.track_length = '0;
        i_rst_n             = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // data before any begin track, on the reset state
        c = random_cmd(CMD_DATA_BYTE);
        c.payload = 8'h5a;
        push_cmd(c);
        c = random_cmd(CMD_BEGIN_TRACK);
        c.sector_count = SECT_FEW;
        push_cmd(c);
        c = random_cmd(CMD_SECTOR_HDR);
        c.id = '0;
        c.deleted = 1'b0;
        push_cmd(c);
        c = random_cmd(CMD_DATA_BYTE);
        c.payload = 8'h00;
        push_cmd(c);
        c.payload = 8'hff;
        push_cmd(c);
        push_cmd(random_cmd(CMD_END_SECTOR));
        // second end track finds the track already full
        push_cmd(random_cmd(CMD_END_TRACK));
        push_cmd(random_cmd(CMD_END_TRACK));
        push_cmd(random_cmd(CMD_RSVD_5));
        push_cmd(random_cmd(CMD_RSVD_7));
        // gap3 boundaries, each seen through an end sector
        foreach (gap3_edges[i]) begin
            c = random_cmd(CMD_BEGIN_TRACK);
            c.sector_count = gap3_edges[i];
            push_cmd(c);
            push_cmd(random_cmd(CMD_END_SECTOR));
        end
        c = random_cmd(CMD_BEGIN_TRACK);
        c.sector_count = 8'd0;
        push_cmd(c);
        c = random_cmd(CMD_SECTOR_HDR);
        c.id = '1;
        c.deleted = 1'b1;
        push_cmd(c);
        wait_idle();

        write_track_length(POS_MAX);
        queue_random_tracks(PHASE_ITEMS);
        wait_idle();

        write_track_length(13'd1);
        queue_random_tracks(PHASE_ITEMS);
        wait_idle();

        // no idling on either side in this phase
        write_track_length(POS_W'($urandom_range(6000, 200)));
        calm = 1'b1;
        queue_random_tracks(PHASE_ITEMS);
        wait_idle();
        calm = 1'b0;

        write_track_length(POS_W'($urandom_range(8191, 1)));
        queue_random_tracks(PHASE_ITEMS);
        wait_idle();

        $display("covered %0d commands and %0d checked runs, %0d track ends, %0d overflowed runs",
                 cmds_taken, runs_seen, tracks_seen, ovf_runs);
        $display("track lengths: reset value, 8191, 1 and two random values");
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_cnt);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
